[rtl/core/psrpe_pkg.sv]
// ----------------------------------------------------------------------------
// psrpe_pkg
// Types, codes and constants shared by the step-rate profile executor files.
// ----------------------------------------------------------------------------
package psrpe_pkg;

   localparam int PHASES_DEF          = 8;
   localparam int DEFAULT_REPEATS_DEF = 1;

   localparam int PERIOD_W = 32;
   localparam int FREQ_W   = 24;
   localparam int SLOPE_W  = 24;
   localparam int COUNT_W  = 16;

   localparam logic [PERIOD_W-1:0] TIMER_CLOCK_RESET = 32'd72000000;
   localparam logic [FREQ_W-1:0]   FREQ_MAX          = 24'hFFFFFF;
   localparam logic [SLOPE_W-1:0]  SLOPE_MAX         = 24'h7FFFFF;
   localparam logic [SLOPE_W-1:0]  SLOPE_MIN         = 24'h800000;

   // register word index taken from paddr[2]
   localparam logic REG_TIMER_CLOCK = 1'b0;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_START = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_BREAK = 2'd3
   } action_type;

   localparam logic [1:0] EVT_NONE  = 2'd0;
   localparam logic [1:0] EVT_DONE  = 2'd1;
   localparam logic [1:0] EVT_ESTOP = 2'd2;

   typedef struct packed {
      logic [COUNT_W-1:0] updates;
      logic [FREQ_W-1:0]  frequency;
      logic [SLOPE_W-1:0] slope;
      logic [SLOPE_W-1:0] slope_change;
   } phase_entry_type;

   // request payload, last member in the lowest bits
   typedef struct packed {
      logic [2:0]         pad;
      logic               tail_enabled;
      logic               reverse;
      logic [SLOPE_W-1:0] slope_change;
      logic [SLOPE_W-1:0] start_slope;
      logic [FREQ_W-1:0]  start_frequency;
      logic [COUNT_W-1:0] phase_updates;
      logic [2:0]         phase_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          event_code;
      logic [2:0]          exec_phase;
      logic                direction;
      logic                motor_enable;
      logic                running;
      logic [COUNT_W-1:0]  repeat_count;
      logic [PERIOD_W-1:0] timer_period;
   } rsp_item_type;

   typedef struct packed {
      logic                start;
      logic [PERIOD_W-1:0] dividend;
      logic [FREQ_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [PERIOD_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/psrpe_ram.sv]
// ----------------------------------------------------------------------------
// psrpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psrpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/psrpe_div.sv]
// ----------------------------------------------------------------------------
// psrpe_div
// Bit-serial restoring divider: one quotient bit per cycle, zero divisor
// answers with an all-ones quotient.
// ----------------------------------------------------------------------------
module psrpe_div
   import psrpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(PERIOD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [FREQ_W:0]     rem_ff, rem_in;
   logic [PERIOD_W-1:0] quo_ff, quo_in;
   logic [FREQ_W-1:0]   den_ff, den_in;

   logic [FREQ_W:0] rem_shift;
   logic            fits;

   assign rem_shift = {rem_ff[FREQ_W-1:0], quo_ff[PERIOD_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         if (div_req.divisor == '0) begin
            quo_in  = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = '0;
            quo_in  = div_req.dividend;
            den_in  = div_req.divisor;
            cnt_in  = CNT_W'(PERIOD_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // shift the next dividend bit in, subtract where it fits
         rem_in = fits ? (rem_shift - {1'b0, den_ff}) : rem_shift;
         quo_in = {quo_ff[PERIOD_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/core/phased_step_rate_profile_executor_top.sv]
// ----------------------------------------------------------------------------
// phased_step_rate_profile_executor_top
// S-curve step-rate generator driven by a table of motion phases.
// ----------------------------------------------------------------------------
// Usage: the req stream carries one item per transfer; req_tuser holds the
// action (load, start, update tick, break), req_tdata the phase fields. Every
// accepted item yields exactly one rsp transfer with the programmed timer
// period, repeat count, status lines, executing phase and event code. The
// timer_clock register sits on the csr APB port at byte address 0.
// Items are processed one at a time; the next one is taken the cycle after
// the result is registered. Load, break and an ignored tick go from the
// execute state straight to the result register. An update tick runs the
// 32-step bit-serial period divider, which returns all ones without
// stepping for a zero frequency; when the tick ends a phase, a phase scan
// follows, with one phase-RAM read per table entry examined. A start scans
// the table the same way and runs the divider once it enters a phase.
// The result sits in an output register; the next item is accepted while it
// waits, but its own result holds until the receiver takes the previous one.
// A stalled receiver therefore stalls the block after at most one more item.
// Reset (synchronous) clears the run state, sets the period to all ones and
// the repeat count to DEFAULT_REPEATS - 1; the phase table is not cleared and
// must be loaded before it is used.
// ----------------------------------------------------------------------------
module phased_step_rate_profile_executor_top
   import psrpe_pkg::*;
#(
   parameter int PHASES          = PHASES_DEF,
   parameter int DEFAULT_REPEATS = DEFAULT_REPEATS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // phase_index[2:0], phase_updates[18:3], start_frequency[42:19],
   // start_slope[66:43], slope_change[90:67], reverse[91], tail_enabled[92]
   input  logic [95:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // timer_period[31:0], repeat_count[47:32], running[48], motor_enable[49],
   // direction[50], exec_phase[53:51], event_code[55:54]
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PH_W = $clog2(PHASES);
   localparam logic [PH_W-1:0]    TAIL_IDX = PH_W'(PHASES - 1);
   localparam logic [COUNT_W-1:0] REP_INIT = COUNT_W'(DEFAULT_REPEATS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_CHECK,
      S_DIVGO,
      S_DIVWAIT,
      S_ADV,
      S_EMIT
   } state_type;

   // configuration
   logic [PERIOD_W-1:0] timer_clock_ff;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TIMER_CLOCK) ? timer_clock_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_clock_ff <= TIMER_CLOCK_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_TIMER_CLOCK)) begin
         timer_clock_ff <= csr_pwdata;
      end
   end

   // control and run state
   state_type           state_ff, state_in;
   req_item_type        item_ff, item_in;
   action_type          action_ff, action_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [SLOPE_W-1:0]  slope_ff, slope_in;
   logic [SLOPE_W-1:0]  jerk_ff, jerk_in;
   logic [COUNT_W-1:0]  upd_ff, upd_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                running_ff, running_in;
   logic                enable_ff, enable_in;
   logic                reverse_ff, reverse_in;
   logic                tail_ff, tail_in;
   logic [COUNT_W-1:0]  repeats_ff, repeats_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PH_W-1:0]     scan_ff, scan_in;
   logic                start_mode_ff, start_mode_in;
   logic                adv_ff, adv_in;
   logic [1:0]          event_ff, event_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;

   // phase table
   phase_entry_type entry_wr, entry_rd;
   logic            ram_we;
   logic [PH_W+2:0] load_idx_ext;
   logic            load_ok;

   assign load_idx_ext = {{PH_W{1'b0}}, item_ff.phase_index};
   assign load_ok      = load_idx_ext < (PH_W + 3)'(PHASES);

   assign entry_wr.updates      = item_ff.phase_updates;
   assign entry_wr.frequency    = item_ff.start_frequency;
   assign entry_wr.slope        = item_ff.start_slope;
   assign entry_wr.slope_change = item_ff.slope_change;

   psrpe_ram #(
      .WIDTH($bits(phase_entry_type)),
      .DEPTH(PHASES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(load_idx_ext[PH_W-1:0]),
      .wr_data(entry_wr),
      .rd_addr(scan_ff),
      .rd_data(entry_rd)
   );

   // period divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign div_req.start    = (state_ff == S_DIVGO);
   assign div_req.dividend = timer_clock_ff;
   assign div_req.divisor  = freq_ff;

   psrpe_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // saturating rate update
   logic signed [FREQ_W+1:0] f_sum;
   logic signed [SLOPE_W:0]  s_sum;
   logic [FREQ_W-1:0]        f_sat;
   logic [SLOPE_W-1:0]       s_sat;

   assign f_sum = $signed({2'b00, freq_ff}) + $signed({{2{slope_ff[SLOPE_W-1]}}, slope_ff});
   assign s_sum = $signed({slope_ff[SLOPE_W-1], slope_ff})
                + $signed({jerk_ff[SLOPE_W-1], jerk_ff});

   always_comb begin
      if (f_sum[FREQ_W+1]) begin
         f_sat = '0;
      end else if (f_sum[FREQ_W]) begin
         f_sat = FREQ_MAX;
      end else begin
         f_sat = f_sum[FREQ_W-1:0];
      end
      if (s_sum[SLOPE_W] != s_sum[SLOPE_W-1]) begin
         s_sat = s_sum[SLOPE_W] ? SLOPE_MIN : SLOPE_MAX;
      end else begin
         s_sat = s_sum[SLOPE_W-1:0];
      end
   end

   logic [COUNT_W-1:0] upd_dec;
   logic               out_free;
   logic [PH_W+2:0]    phase_ext;

   assign upd_dec    = upd_ff - 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign phase_ext  = {3'b000, phase_ff};
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      action_in     = action_ff;
      freq_in       = freq_ff;
      slope_in      = slope_ff;
      jerk_in       = jerk_ff;
      upd_in        = upd_ff;
      phase_in      = phase_ff;
      running_in    = running_ff;
      enable_in     = enable_ff;
      reverse_in    = reverse_ff;
      tail_in       = tail_ff;
      repeats_in    = repeats_ff;
      period_in     = period_ff;
      scan_in       = scan_ff;
      start_mode_in = start_mode_ff;
      adv_in        = adv_ff;
      event_in      = event_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in   = req_tdata;
               action_in = action_type'(req_tuser);
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            event_in = EVT_NONE;
            adv_in   = 1'b0;
            state_in = S_EMIT;
            unique case (action_ff)
               ACT_LOAD: begin
                  ram_we = load_ok;
               end
               ACT_START: begin
                  running_in    = 1'b0;
                  tail_in       = item_ff.tail_enabled;
                  repeats_in    = REP_INIT;
                  start_mode_in = 1'b1;
                  scan_in       = '0;
                  state_in      = S_READ;
               end
               ACT_TICK: begin
                  if (running_ff) begin
                     freq_in  = f_sat;
                     slope_in = s_sat;
                     upd_in   = upd_dec;
                     adv_in   = (upd_dec == '0);
                     state_in = S_DIVGO;
                  end
               end
               ACT_BREAK: begin
                  if (running_ff) begin
                     running_in = 1'b0;
                     enable_in  = 1'b0;
                     event_in   = EVT_ESTOP;
                  end
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end
         S_READ: begin
            // wait for the table read of scan_ff
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((scan_ff != TAIL_IDX) && (entry_rd.updates == '0)) begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_READ;
            end else if ((scan_ff != TAIL_IDX)
                         || (tail_ff && (entry_rd.updates != '0))) begin
               // enter the phase
               freq_in  = entry_rd.frequency;
               slope_in = entry_rd.slope;
               jerk_in  = entry_rd.slope_change;
               phase_in = scan_ff;
               if (scan_ff == TAIL_IDX) begin
                  upd_in     = COUNT_W'(1);
                  repeats_in = entry_rd.updates - 1'b1;
               end else begin
                  upd_in = entry_rd.updates;
               end
               if (start_mode_ff) begin
                  running_in = 1'b1;
                  enable_in  = 1'b1;
                  reverse_in = item_ff.reverse;
                  adv_in     = 1'b0;
                  state_in   = S_DIVGO;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               // no phase left: a start does nothing, a run completes
               if (!start_mode_ff) begin
                  phase_in   = TAIL_IDX;
                  running_in = 1'b0;
                  event_in   = EVT_DONE;
               end
               state_in = S_EMIT;
            end
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_rsp.done) begin
               period_in = div_rsp.quotient;
               state_in  = adv_ff ? S_ADV : S_EMIT;
            end
         end
         S_ADV: begin
            if (phase_ff >= TAIL_IDX) begin
               running_in = 1'b0;
               event_in   = EVT_DONE;
               state_in   = S_EMIT;
            end else begin
               start_mode_in = 1'b0;
               scan_in       = phase_ff + 1'b1;
               state_in      = S_READ;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.timer_period = period_ff;
               rsp_data_in.repeat_count = repeats_ff;
               rsp_data_in.running      = running_ff;
               rsp_data_in.motor_enable = enable_ff;
               rsp_data_in.direction    = reverse_ff;
               rsp_data_in.exec_phase   = phase_ext[2:0];
               rsp_data_in.event_code   = event_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         freq_ff      <= '0;
         slope_ff     <= '0;
         jerk_ff      <= '0;
         upd_ff       <= '0;
         phase_ff     <= '0;
         running_ff   <= 1'b0;
         enable_ff    <= 1'b0;
         reverse_ff   <= 1'b0;
         tail_ff      <= 1'b0;
         repeats_ff   <= REP_INIT;
         period_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         slope_ff     <= slope_in;
         jerk_ff      <= jerk_in;
         upd_ff       <= upd_in;
         phase_ff     <= phase_in;
         running_ff   <= running_in;
         enable_ff    <= enable_in;
         reverse_ff   <= reverse_in;
         tail_ff      <= tail_in;
         repeats_ff   <= repeats_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      action_ff     <= action_in;
      scan_ff       <= scan_in;
      start_mode_ff <= start_mode_in;
      adv_ff        <= adv_in;
      event_ff      <= event_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/psrpe_chk.sv]
// ----------------------------------------------------------------------------
// psrpe_chk
// Port-level checks of the step-rate profile executor, bound to the top.
// ----------------------------------------------------------------------------
module psrpe_chk
   import psrpe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an emergency stop drops both running and the motor enable
   a_estop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[55:54] == EVT_ESTOP) |-> !rsp_tdata[48] && !rsp_tdata[49])
      else $error("emergency stop left the motor active");

   // completion ends the run
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[55:54] == EVT_DONE) |-> !rsp_tdata[48])
      else $error("completion reported while running");

   // a running motion always has the driver enabled
   a_run_en: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48] |-> rsp_tdata[49])
      else $error("running without motor enable");

endmodule

bind phased_step_rate_profile_executor_top psrpe_chk u_psrpe_chk (.*);

[test/tb_phased_step_rate_profile_executor_top.sv]
// ----------------------------------------------------------------------------
// tb_phased_step_rate_profile_executor_top
// Self-checking bench for the phased step-rate profile executor. Phase loads,
// starts, update ticks and breaks go in on the req stream and every rsp
// transfer is checked against an in-bench rate and status predictor. The
// timer clock register is reprogrammed between batches and read back.
// ----------------------------------------------------------------------------
module tb_phased_step_rate_profile_executor_top;
   timeunit 1ns;
   timeprecision 1ps;
   import psrpe_pkg::*;

   localparam int TAIL_SLOT   = PHASES_DEF - 1;
   localparam int IDLE_PCT    = 30;
   localparam int BATCH_ITEMS = 310;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      action_type   act;
      req_item_type body;
   } motion_cmd_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   phased_step_rate_profile_executor_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   motion_cmd_type pending_cmds[$];
   rsp_item_type   expected_status[$];
   int             error_count = 0;
   int             cycle_count = 0;
   bit             req_fired   = 1'b0;
   bit             drained     = 1'b0;
   logic           quiet_window;
   logic [15:0]    gen_counts [PHASES_DEF];

   assign quiet_window = (cycle_count >= 20000) && (cycle_count < 32000);

   // predictor state
   logic [31:0]        clk_hz = TIMER_CLOCK_RESET;
   logic [15:0]        tbl_updates [PHASES_DEF];
   logic [23:0]        tbl_freq [PHASES_DEF];
   logic signed [23:0] tbl_slope [PHASES_DEF];
   logic signed [23:0] tbl_jerk [PHASES_DEF];
   logic [23:0]        cur_freq = '0;
   logic signed [23:0] cur_slope = '0;
   logic signed [23:0] cur_jerk = '0;
   logic [15:0]        updates_left = '0;
   int                 phase_now = 0;
   logic               running = 1'b0;
   logic               motor_on = 1'b0;
   logic               reverse_on = 1'b0;
   logic               tail_on = 1'b0;
   logic [15:0]        repeats_now = 16'(DEFAULT_REPEATS_DEF - 1);
   logic [31:0]        period_now = '1;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("phased_step_rate_profile_executor_top regression: fail");
      $finish;
   end

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   function automatic logic [31:0] period_for(logic [23:0] f);
      if (f == 0) return '1;
      return clk_hz / {8'd0, f};
   endfunction

   function automatic void enter_table_phase(int p);
      cur_freq  = tbl_freq[p];
      cur_slope = tbl_slope[p];
      cur_jerk  = tbl_jerk[p];
      phase_now = p;
      if (p == TAIL_SLOT) begin
         updates_left = 16'd1;
         repeats_now  = tbl_updates[p] - 16'd1;
      end else begin
         updates_left = tbl_updates[p];
      end
   endfunction

   // Move past an exhausted phase; skip empty ones, end at the tail slot.
   function automatic logic [1:0] seek_next_phase();
      int p;
      p = phase_now;
      if (p >= TAIL_SLOT) begin
         running = 1'b0;
         return EVT_DONE;
      end
      do begin
         p++;
         if (p == TAIL_SLOT && !tail_on) begin
            phase_now = p;
            running   = 1'b0;
            return EVT_DONE;
         end
      end while (p < TAIL_SLOT && tbl_updates[p] == 0);
      if (tbl_updates[p] == 0) begin
         phase_now = p;
         running   = 1'b0;
         return EVT_DONE;
      end
      enter_table_phase(p);
      return EVT_NONE;
   endfunction

   function automatic rsp_item_type next_rate_status(action_type act, req_item_type it);
      logic [1:0]   evt;
      int           p;
      bit           found;
      longint       f_sum;
      longint       s_sum;
      rsp_item_type st;
      evt = EVT_NONE;
      case (act)
         ACT_LOAD: begin
            tbl_updates[it.phase_index] = it.phase_updates;
            tbl_freq[it.phase_index]    = it.start_frequency;
            tbl_slope[it.phase_index]   = it.start_slope;
            tbl_jerk[it.phase_index]    = it.slope_change;
         end
         ACT_START: begin
            running     = 1'b0;
            tail_on     = it.tail_enabled;
            repeats_now = 16'(DEFAULT_REPEATS_DEF - 1);
            found       = 1'b0;
            p           = 0;
            while (p < TAIL_SLOT && !found) begin
               if (tbl_updates[p] != 0) found = 1'b1;
               else p++;
            end
            if (!found && tail_on && tbl_updates[TAIL_SLOT] != 0) begin
               p     = TAIL_SLOT;
               found = 1'b1;
            end
            if (found) begin
               enter_table_phase(p);
               period_now = period_for(cur_freq);
               running    = 1'b1;
               motor_on   = 1'b1;
               reverse_on = it.reverse;
            end
         end
         ACT_TICK: begin
            if (running) begin
               f_sum = longint'(cur_freq) + longint'(cur_slope);
               s_sum = longint'(cur_slope) + longint'(cur_jerk);
               if (f_sum < 0) f_sum = 0;
               else if (f_sum > longint'(FREQ_MAX)) f_sum = longint'(FREQ_MAX);
               if (s_sum < longint'($signed(SLOPE_MIN))) s_sum = longint'($signed(SLOPE_MIN));
               else if (s_sum > longint'(SLOPE_MAX)) s_sum = longint'(SLOPE_MAX);
               cur_freq     = f_sum[23:0];
               cur_slope    = s_sum[23:0];
               period_now   = period_for(cur_freq);
               updates_left = updates_left - 16'd1;
               if (updates_left == 0) evt = seek_next_phase();
            end
         end
         default: begin
            if (running) begin
               running  = 1'b0;
               motor_on = 1'b0;
               evt      = EVT_ESTOP;
            end
         end
      endcase
      st.timer_period = period_now;
      st.repeat_count = repeats_now;
      st.running      = running;
      st.motor_enable = motor_on;
      st.direction    = reverse_on;
      st.exec_phase   = 3'(phase_now);
      st.event_code   = evt;
      return st;
   endfunction

   // check results first, then record the accepted item
   always @(posedge clock) begin : monitor
      rsp_item_type got;
      rsp_item_type want;
      cycle_count++;
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_status.size() == 0) begin
               note_failure($sformatf("unexpected rsp transfer %h at cycle %0d",
                                      got, cycle_count));
            end else begin
               want = expected_status.pop_front();
               if (got.timer_period !== want.timer_period ||
                   got.repeat_count !== want.repeat_count ||
                   got.running !== want.running ||
                   got.motor_enable !== want.motor_enable ||
                   got.direction !== want.direction ||
                   got.exec_phase !== want.exec_phase ||
                   got.event_code !== want.event_code) begin
                  note_failure($sformatf(
                     {"rsp mismatch at cycle %0d: expected period %0d rep %0d run %b en %b ",
                      "dir %b ph %0d evt %0d, got period %0d rep %0d run %b en %b dir %b ",
                      "ph %0d evt %0d"},
                     cycle_count, want.timer_period, want.repeat_count, want.running,
                     want.motor_enable, want.direction, want.exec_phase, want.event_code,
                     got.timer_period, got.repeat_count, got.running, got.motor_enable,
                     got.direction, got.exec_phase, got.event_code));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            expected_status.push_back(next_rate_status(action_type'(req_tuser),
                                                       req_item_type'(req_tdata)));
         end
      end
      drained = pending_cmds.size() == 0 && !req_tvalid && expected_status.size() == 0;
   end

   always @(negedge clock) begin : driver
      motion_cmd_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_fired)) begin
         if (pending_cmds.size() != 0 && (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
            cmd = pending_cmds.pop_front();
            req_tuser  <= cmd.act;
            req_tdata  <= cmd.body;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && (quiet_window || $urandom_range(99) >= IDLE_PCT);
   end

   function automatic logic [23:0] pick_freq();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return FREQ_MAX;
         2: return 24'($urandom_range(1, 50));
         3: return 24'($urandom_range(1, 5000));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] pick_slope();
      logic [23:0] v;
      case ($urandom_range(0, 7))
         0: return SLOPE_MAX;
         1: return SLOPE_MIN;
         2: return '0;
         3, 4: begin
            v = 24'($urandom_range(0, 128));
            return v - 24'd64;
         end
         5: begin
            v = 24'($urandom_range(0, 4000));
            return v - 24'd2000;
         end
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic queue_item(action_type act, logic [2:0] idx, logic [15:0] upd,
                             logic [23:0] f, logic [23:0] s, logic [23:0] j,
                             logic rev, logic tail);
      motion_cmd_type cmd;
      cmd.act                  = act;
      cmd.body.pad             = '0;
      cmd.body.tail_enabled    = tail;
      cmd.body.reverse         = rev;
      cmd.body.slope_change    = j;
      cmd.body.start_slope     = s;
      cmd.body.start_frequency = f;
      cmd.body.phase_updates   = upd;
      cmd.body.phase_index     = idx;
      pending_cmds.push_back(cmd);
      if (act == ACT_LOAD) gen_counts[idx] = upd;
   endtask

   task automatic queue_noisy(action_type act);
      queue_item(act, 3'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic queue_random_load();
      logic [15:0] upd;
      case ($urandom_range(0, 9))
         0, 1, 2: upd = '0;
         8:       upd = 16'($urandom_range(7, 40));
         9:       upd = 16'($urandom);
         default: upd = 16'($urandom_range(1, 6));
      endcase
      queue_item(ACT_LOAD, 3'($urandom), upd, pick_freq(), pick_slope(), pick_slope(),
                 1'($urandom), 1'($urandom));
   endtask

   // One motion: a few table loads, a start, one tick per planned update (at
   // most 60), sometimes cut short by a break, then a little noise.
   task automatic queue_random_motion(output int counted);
      int planned;
      int brk_at;
      int k;
      logic tail_pick;
      counted = 0;
      repeat ($urandom_range(0, 3)) begin
         queue_random_load();
         counted++;
      end
      tail_pick = $urandom_range(0, 4) != 0;
      queue_item(ACT_START, 3'($urandom), 16'($urandom), pick_freq(), pick_slope(),
                 pick_slope(), 1'($urandom), tail_pick);
      counted++;
      planned = tail_pick ? 1 : 0;
      for (k = 0; k < TAIL_SLOT; k++) planned += gen_counts[k];
      if (planned > 60) planned = 60;
      brk_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, planned)) : -1;
      for (k = 0; k < planned && k != brk_at; k++) begin
         if ($urandom_range(0, 19) == 0) begin
            queue_random_load();
            counted++;
         end
         queue_noisy(ACT_TICK);
         counted++;
      end
      if (brk_at >= 0) begin
         queue_noisy(ACT_BREAK);
         counted++;
      end
      repeat ($urandom_range(0, 2)) begin
         queue_noisy(ACT_TICK);
         counted++;
      end
      if ($urandom_range(0, 9) == 0) begin
         queue_noisy(action_type'($urandom_range(0, 3)));
         counted++;
      end
   endtask

   task automatic csr_transfer(logic wr, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {REG_TIMER_CLOCK, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr) begin
         clk_hz = value;
      end else if (csr_prdata !== clk_hz) begin
         note_failure($sformatf("timer_clock readback: expected %0d, got %0d",
                                clk_hz, csr_prdata));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      do @(negedge clock); while (!drained);
      repeat (8) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] clk_plan [5];
      int          counted;
      int          got;
      int          batch;
      int          k;
      clk_plan = '{TIMER_CLOCK_RESET, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd12_000_000};
      clk_plan[3] = $urandom_range(32'hFFFF_FFFF, 2);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_transfer(1'b0, '0);
      @(posedge clock);

      // fill the whole table before anything can read it
      queue_item(ACT_LOAD, 3'd0, 16'd3, FREQ_MAX, SLOPE_MAX, SLOPE_MAX, 1'b0, 1'b0);
      queue_item(ACT_LOAD, 3'd1, 16'd0, pick_freq(), pick_slope(), pick_slope(), 1'b1, 1'b1);
      queue_item(ACT_LOAD, 3'd2, 16'd2, 24'd0, SLOPE_MIN, SLOPE_MIN, 1'b0, 1'b0);
      queue_item(ACT_LOAD, 3'd3, 16'hFFFF, 24'd1000, 24'd0, 24'd0, 1'b0, 1'b0);
      for (k = 4; k < TAIL_SLOT; k++)
         queue_item(ACT_LOAD, 3'(k), 16'd0, pick_freq(), pick_slope(), pick_slope(), 1'b0, 1'b0);
      queue_item(ACT_LOAD, 3'(TAIL_SLOT), 16'd5, 24'd1, 24'd0, 24'd0, 1'b0, 1'b0);
      // tick and break with nothing running
      queue_noisy(ACT_TICK);
      queue_noisy(ACT_BREAK);
      // saturate high, saturate to zero frequency, then break inside phase 3
      queue_item(ACT_START, 3'd0, 16'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
      repeat (6) queue_noisy(ACT_TICK);
      queue_noisy(ACT_BREAK);
      // empty every regular phase: no start without tail, tail-only motion with it
      queue_item(ACT_LOAD, 3'd0, 16'd0, 24'd5, 24'd0, 24'd0, 1'b0, 1'b0);
      queue_item(ACT_LOAD, 3'd2, 16'd0, 24'd5, 24'd0, 24'd0, 1'b0, 1'b0);
      queue_item(ACT_LOAD, 3'd3, 16'd0, 24'd5, 24'd0, 24'd0, 1'b0, 1'b0);
      queue_item(ACT_START, 3'd7, 16'hFFFF, FREQ_MAX, SLOPE_MIN, SLOPE_MAX, 1'b0, 1'b0);
      queue_item(ACT_START, 3'd7, 16'hFFFF, FREQ_MAX, SLOPE_MIN, SLOPE_MAX, 1'b0, 1'b1);
      queue_noisy(ACT_TICK);
      // zero-count tail ends the motion after the last regular phase
      queue_item(ACT_LOAD, 3'd0, 16'd1, 24'd123456, 24'hFFFFFB, 24'd1, 1'b0, 1'b0);
      queue_item(ACT_LOAD, 3'(TAIL_SLOT), 16'd0, 24'd77, 24'd0, 24'd0, 1'b0, 1'b0);
      queue_item(ACT_START, 3'd0, 16'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
      queue_noisy(ACT_TICK);

      for (batch = 0; batch < 5; batch++) begin
         if (batch > 0) begin
            wait_drained();
            csr_transfer(1'b1, clk_plan[batch]);
            csr_transfer(1'b0, '0);
            @(posedge clock);
         end
         counted = 0;
         while (counted < BATCH_ITEMS) begin
            queue_random_motion(got);
            counted += got;
         end
      end

      wait_drained();
      repeat (100) @(negedge clock);
      if (error_count == 0) begin
         $display("phased_step_rate_profile_executor_top regression: pass");
      end else begin
         $display("phased_step_rate_profile_executor_top regression: fail");
      end
      $finish;
   end

endmodule
